// ===== rtl/mpool_pkg.sv =====
package mpool_pkg;

  // Default build limits of the block.
  localparam int DEF_MAX_WINDOW      = 8;
  localparam int DEF_MAX_PLANE_WIDTH = 1024;
  localparam int DEF_SAMPLE_BITS     = 16;

  // Plane height limit and the row counter that follows from it.
  localparam int MAX_PLANE_HEIGHT = 1024;
  localparam int ROW_W            = $clog2(MAX_PLANE_HEIGHT);
  localparam int PH_W             = $clog2(MAX_PLANE_HEIGHT + 1);

  // Configuration register widths and write port geometry.
  localparam int WIN_CFG_W   = 4;
  localparam int PLANE_CFG_W = 11;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_INDEX_W = 3;

  // Register values after reset.
  localparam logic [WIN_CFG_W-1:0]   RST_WINDOW_WIDTH  = 4'd2;
  localparam logic [WIN_CFG_W-1:0]   RST_WINDOW_HEIGHT = 4'd2;
  localparam logic [WIN_CFG_W-1:0]   RST_STEP_SIZE     = 4'd2;
  localparam logic [PLANE_CFG_W-1:0] RST_PLANE_WIDTH   = 11'd28;
  localparam logic [PLANE_CFG_W-1:0] RST_PLANE_HEIGHT  = 11'd28;

  // Register map of the configuration port.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WINDOW_WIDTH  = 3'd0,
    REG_WINDOW_HEIGHT = 3'd1,
    REG_STEP_SIZE     = 3'd2,
    REG_PLANE_WIDTH   = 3'd3,
    REG_PLANE_HEIGHT  = 3'd4
  } cfg_reg_t;

endpackage

// ===== rtl/mpool_if.sv =====
// Sample request channel.
interface mpool_sample_if
  import mpool_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// Pooled result request channel.
interface mpool_result_if
  import mpool_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] pooled_value;
  logic                          row_end;
  logic                          plane_end;

  modport source (output valid, output pooled_value, output row_end, output plane_end,
                  input ready);
  modport sink   (input valid, input pooled_value, input row_end, input plane_end,
                  output ready);
endinterface

// ===== rtl/max_pooling_2d_stream.sv =====
// Streaming two-dimensional max pooling.
// Samples enter on the feed channel in raster order, row after row of a plane and
// then the next channel plane. Each accepted request with a valid/ready handshake
// carries one signed sample. The pooled channel returns the maximum of every
// window_width by window_height window whose origin lies on multiples of
// step_size, with row_end and plane_end marking the last result of an output row
// and of a plane. Rows and columns that cannot fill a window give no result.
// The configuration port takes a register write in any cycle; the user must write
// it only while no requests are in flight, which the block does not enforce.
// Throughput is one sample per clock while the output queue has room. The line
// store holds one entry per column with all buffered rows side by side, so each
// sample costs one read and one write of that memory; a result passes the read
// stage, the window stage and the output queue after its sample is accepted.
// Results wait in a four-entry output queue. While the receiver stalls, samples
// are still taken until the queue and the pipeline stages together are full.
// Reset clears the positions, phases, pipeline and queue and restores the
// register defaults; the line store needs no clearing and is ready at once.
module max_pooling_2d_stream
  import mpool_pkg::*;
#(
  parameter int MAX_WINDOW      = DEF_MAX_WINDOW,
  parameter int MAX_PLANE_WIDTH = DEF_MAX_PLANE_WIDTH,
  parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  mpool_sample_if.sink           feed,
  mpool_result_if.source         pooled
);

  localparam int LINE_SLOTS = (MAX_WINDOW > 1) ? MAX_WINDOW - 1 : 1;
  localparam int SLOT_W     = (LINE_SLOTS > 1) ? $clog2(LINE_SLOTS) : 1;
  localparam int AGE_W      = $clog2(LINE_SLOTS + 1);
  localparam int ENTRY_W    = LINE_SLOTS * SAMPLE_BITS;
  localparam int COL_W      = $clog2(MAX_PLANE_WIDTH);
  localparam int PW_W       = $clog2(MAX_PLANE_WIDTH + 1);
  localparam int WIN_W      = $clog2(MAX_WINDOW + 1);
  localparam int PHASE_W    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int TAP_N      = (MAX_WINDOW > 1) ? MAX_WINDOW - 1 : 1;
  localparam int CNT_W      = ((PW_W > PH_W) ? PW_W : PH_W) + 1;
  localparam int FIFO_DEPTH = 4;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          row_end;
    logic                          plane_end;
  } result_t;

  // Configuration registers.
  logic [WIN_CFG_W-1:0]   window_width;
  logic [WIN_CFG_W-1:0]   window_height;
  logic [WIN_CFG_W-1:0]   step_size;
  logic [PLANE_CFG_W-1:0] plane_width;
  logic [PLANE_CFG_W-1:0] plane_height;

  // Effective, saturated settings.
  logic [WIN_W-1:0] w_eff;
  logic [WIN_W-1:0] h_eff;
  logic [WIN_W-1:0] s_eff;
  logic [PW_W-1:0]  pw_eff;
  logic [PH_W-1:0]  ph_eff;

  // Raster position state.
  logic [COL_W-1:0]   col_pos;
  logic [ROW_W-1:0]   row_pos;
  logic [PHASE_W-1:0] col_phase;
  logic [PHASE_W-1:0] row_phase;
  logic [SLOT_W-1:0]  row_slot;
  logic [COL_W-1:0]   col_pos_next;
  logic [ROW_W-1:0]   row_pos_next;
  logic [PHASE_W-1:0] col_phase_next;
  logic [PHASE_W-1:0] row_phase_next;
  logic [SLOT_W-1:0]  row_slot_next;
  logic [CNT_W-1:0]   c_ext;
  logic [CNT_W-1:0]   r_ext;
  logic               last_col;
  logic               last_row;
  logic               vert_a;
  logic               emit_a;
  logic               re_a;
  logic               pe_a;
  logic               accept;
  logic [FCNT_W-1:0]  credit;

  // Line store access.
  logic               fwd_hit;
  logic [ENTRY_W-1:0] rd_data;
  logic [ENTRY_W-1:0] entry;
  logic [ENTRY_W-1:0] entry_new;

  // Read stage.
  logic                          p1_valid;
  logic signed [SAMPLE_BITS-1:0] p1_sample;
  logic [COL_W-1:0]              p1_col;
  logic [SLOT_W-1:0]             p1_slot;
  logic                          p1_vert;
  logic                          p1_emit;
  logic                          p1_re;
  logic                          p1_pe;
  logic                          p1_fwd_hit;
  logic [ENTRY_W-1:0]            p1_fwd_data;
  logic signed [SAMPLE_BITS-1:0] vmax;

  // Window stage.
  logic                          p2_valid;
  logic signed [SAMPLE_BITS-1:0] p2_vmax;
  logic                          p2_vert;
  logic                          p2_emit;
  logic                          p2_re;
  logic                          p2_pe;
  logic signed [SAMPLE_BITS-1:0] taps [TAP_N];
  logic signed [SAMPLE_BITS-1:0] best;

  // Output queue.
  result_t           fifo_mem [FIFO_DEPTH];
  logic [FPTR_W-1:0] wr_ptr;
  logic [FPTR_W-1:0] rd_ptr;
  logic [FCNT_W-1:0] fifo_count;
  logic              push;
  logic              pop;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_width  <= RST_WINDOW_WIDTH;
      window_height <= RST_WINDOW_HEIGHT;
      step_size     <= RST_STEP_SIZE;
      plane_width   <= RST_PLANE_WIDTH;
      plane_height  <= RST_PLANE_HEIGHT;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_WINDOW_WIDTH:  window_width  <= cfg_data[WIN_CFG_W-1:0];
        REG_WINDOW_HEIGHT: window_height <= cfg_data[WIN_CFG_W-1:0];
        REG_STEP_SIZE:     step_size     <= cfg_data[WIN_CFG_W-1:0];
        REG_PLANE_WIDTH:   plane_width   <= cfg_data[PLANE_CFG_W-1:0];
        REG_PLANE_HEIGHT:  plane_height  <= cfg_data[PLANE_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the settings; zero counts as one.
  always_comb begin
    if (window_width == '0) w_eff = WIN_W'(1);
    else if (window_width > MAX_WINDOW) w_eff = WIN_W'(MAX_WINDOW);
    else w_eff = WIN_W'(window_width);

    if (window_height == '0) h_eff = WIN_W'(1);
    else if (window_height > MAX_WINDOW) h_eff = WIN_W'(MAX_WINDOW);
    else h_eff = WIN_W'(window_height);

    if (step_size == '0) s_eff = WIN_W'(1);
    else if (step_size > MAX_WINDOW) s_eff = WIN_W'(MAX_WINDOW);
    else s_eff = WIN_W'(step_size);

    if (plane_width == '0) pw_eff = PW_W'(1);
    else if (plane_width > MAX_PLANE_WIDTH) pw_eff = PW_W'(MAX_PLANE_WIDTH);
    else pw_eff = PW_W'(plane_width);

    if (plane_height == '0) ph_eff = PH_W'(1);
    else if (plane_height > MAX_PLANE_HEIGHT) ph_eff = PH_W'(MAX_PLANE_HEIGHT);
    else ph_eff = PH_W'(plane_height);
  end

  // Admission: the queue must have room for everything in the pipeline.
  assign credit     = fifo_count + FCNT_W'(p1_valid) + FCNT_W'(p2_valid);
  assign feed.ready = (credit < FCNT_W'(FIFO_DEPTH));
  assign accept     = feed.valid && feed.ready;

  // Window flags and the next raster position of the incoming sample.
  always_comb begin
    c_ext  = CNT_W'(col_pos);
    r_ext  = CNT_W'(row_pos);
    vert_a = (r_ext + 1'b1 >= CNT_W'(h_eff));
    emit_a = vert_a && (c_ext + 1'b1 >= CNT_W'(w_eff)) &&
             (row_phase == '0) && (col_phase == '0);
    re_a   = (c_ext + CNT_W'(s_eff) >= CNT_W'(pw_eff));
    pe_a   = re_a && (r_ext + CNT_W'(s_eff) >= CNT_W'(ph_eff));

    last_col     = (c_ext + 1'b1 >= CNT_W'(pw_eff));
    col_pos_next = last_col ? '0 : col_pos + 1'b1;
    if (CNT_W'(col_pos_next) < CNT_W'(w_eff)) col_phase_next = '0;
    else if (WIN_W'(col_phase) + 1'b1 >= s_eff) col_phase_next = '0;
    else col_phase_next = col_phase + 1'b1;

    last_row     = (r_ext + 1'b1 >= CNT_W'(ph_eff));
    row_pos_next = last_row ? '0 : row_pos + 1'b1;
    if (CNT_W'(row_pos_next) < CNT_W'(h_eff)) row_phase_next = '0;
    else if (WIN_W'(row_phase) + 1'b1 >= s_eff) row_phase_next = '0;
    else row_phase_next = row_phase + 1'b1;

    // Line store slot of the row, rotating through the buffered rows.
    if (last_row || row_slot == SLOT_W'(LINE_SLOTS - 1)) row_slot_next = '0;
    else row_slot_next = row_slot + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos   <= '0;
      row_pos   <= '0;
      col_phase <= '0;
      row_phase <= '0;
      row_slot  <= '0;
    end else if (accept) begin
      col_pos   <= col_pos_next;
      col_phase <= col_phase_next;
      if (last_col) begin
        row_pos   <= row_pos_next;
        row_phase <= row_phase_next;
        row_slot  <= row_slot_next;
      end
    end
  end

  // Line store: one entry per column, holding every buffered row of it.
  mpool_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_PLANE_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (p1_valid),
    .wr_addr (p1_col),
    .wr_data (entry_new),
    .rd_addr (col_pos),
    .rd_data (rd_data)
  );

  // A read that meets the write of the previous sample to the same column
  // (single-column planes) takes the written entry instead of the stale one.
  assign fwd_hit = p1_valid && (p1_col == col_pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_sample   <= SAMPLE_BITS'(feed.sample);
      p1_col      <= col_pos;
      p1_slot     <= row_slot;
      p1_vert     <= vert_a;
      p1_emit     <= emit_a;
      p1_re       <= re_a;
      p1_pe       <= pe_a;
      p1_fwd_hit  <= fwd_hit;
      p1_fwd_data <= entry_new;
    end
  end

  // Vertical maximum over the rows of the window and write-back of the sample.
  always_comb begin
    logic signed [SAMPLE_BITS-1:0] lane;
    logic [AGE_W-1:0]              age;
    entry     = p1_fwd_hit ? p1_fwd_data : rd_data;
    entry_new = entry;
    vmax      = p1_sample;
    for (int j = 0; j < LINE_SLOTS; j++) begin
      lane = entry[j*SAMPLE_BITS +: SAMPLE_BITS];
      // Rows back from the current one that this slot holds.
      if (p1_slot >= SLOT_W'(j)) age = AGE_W'(p1_slot) - AGE_W'(j);
      else age = AGE_W'(p1_slot) + AGE_W'(LINE_SLOTS) - AGE_W'(j);
      if (age == '0) age = AGE_W'(LINE_SLOTS);
      if ((age < h_eff) && (lane > vmax)) vmax = lane;
      if (p1_slot == SLOT_W'(j)) entry_new[j*SAMPLE_BITS +: SAMPLE_BITS] = p1_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_valid) begin
      p2_vmax <= vmax;
      p2_vert <= p1_vert;
      p2_emit <= p1_emit;
      p2_re   <= p1_re;
      p2_pe   <= p1_pe;
    end
  end

  // Column window: vertical maxima of the previous columns of this row.
  always_ff @(posedge clk) begin
    if (p2_valid && p2_vert) begin
      taps[0] <= p2_vmax;
      for (int k = 1; k < TAP_N; k++) begin
        taps[k] <= taps[k-1];
      end
    end
  end

  always_comb begin
    best = p2_vmax;
    for (int k = 0; k < TAP_N; k++) begin
      if ((WIN_W'(k + 1) < w_eff) && (taps[k] > best)) best = taps[k];
    end
  end

  // Output queue.
  assign push = p2_valid && p2_emit;
  assign pop  = pooled.valid && pooled.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= '{value: best, row_end: p2_re, plane_end: p2_pe};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) fifo_count <= fifo_count + 1'b1;
      else if (pop && !push) fifo_count <= fifo_count - 1'b1;
    end
  end

  assign pooled.valid        = (fifo_count != '0);
  assign pooled.pooled_value = fifo_mem[rd_ptr].value;
  assign pooled.row_end      = fifo_mem[rd_ptr].row_end;
  assign pooled.plane_end    = fifo_mem[rd_ptr].plane_end;

endmodule

// ===== rtl/mpool_ram.sv =====
// Simple dual-port RAM: one write port, one read port, registered read data.
// A read of the entry being written in the same cycle returns the old contents.
module mpool_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/mpool_check.sv =====
// Port-level checks of the pooling block.
module mpool_check
  import mpool_pkg::*;
#(
  parameter int VALUE_W = DEF_SAMPLE_BITS
) (
  input logic               clk,
  input logic               rst,
  input logic               feed_ready,
  input logic               res_valid,
  input logic               res_ready,
  input logic [VALUE_W-1:0] res_value,
  input logic               res_row_end,
  input logic               res_plane_end
);

  // Reset empties the output queue.
  assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result offered straight after reset");

  // The end of a plane is always the end of an output row too.
  assert property (@(posedge clk) disable iff (rst)
                   res_valid |-> (res_row_end || !res_plane_end))
    else $error("plane_end without row_end");

  // A stalled result holds still.
  assert property (@(posedge clk) disable iff (rst)
                   res_valid && !res_ready |=>
                   res_valid && $stable(res_value) && $stable(res_row_end) &&
                   $stable(res_plane_end))
    else $error("stalled result changed");

  // A receiver that was ready in the previous cycle always leaves room for another sample.
  assert property (@(posedge clk) disable iff (rst)
                   $past(res_ready) |-> feed_ready)
    else $error("input held back although the receiver is taking results");

endmodule

bind max_pooling_2d_stream mpool_check #(
  .VALUE_W (SAMPLE_BITS)
) u_mpool_check (
  .clk           (clk),
  .rst           (rst),
  .feed_ready    (feed.ready),
  .res_valid     (pooled.valid),
  .res_ready     (pooled.ready),
  .res_value     (pooled.pooled_value),
  .res_row_end   (pooled.row_end),
  .res_plane_end (pooled.plane_end)
);

// ===== bench/window_max_checker.sv =====
// Watches the sample and pooled channels, predicts every window maximum and
// compares each accepted result with the oldest prediction still waiting.
module window_max_checker
  import mpool_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  mpool_sample_if                feed,
  mpool_result_if                pooled,
  output int unsigned            mismatches,
  output int unsigned            results_due
);

  localparam int LINE_ROWS = DEF_MAX_WINDOW - 1;

  typedef logic signed [DEF_SAMPLE_BITS-1:0] sample_t;

  typedef struct {
    sample_t value;
    logic    row_end;
    logic    plane_end;
  } pooled_t;

  // Shadow copy of the configuration registers.
  logic [WIN_CFG_W-1:0]   win_w_reg;
  logic [WIN_CFG_W-1:0]   win_h_reg;
  logic [WIN_CFG_W-1:0]   step_reg;
  logic [PLANE_CFG_W-1:0] plane_w_reg;
  logic [PLANE_CFG_W-1:0] plane_h_reg;

  // Earlier rows of the current band and the column maxima of the current row.
  sample_t     line_rows [LINE_ROWS][DEF_MAX_PLANE_WIDTH];
  sample_t     col_max [DEF_MAX_WINDOW];
  int unsigned row_pos;
  int unsigned col_pos;
  int unsigned row_phase;
  int unsigned col_phase;

  int unsigned fail_count;
  pooled_t     pooled_due [$];

  // Register values of zero count as one; larger values stop at the limit.
  function automatic int unsigned clamp_size(input int unsigned raw, input int unsigned limit);
    if (raw == 0) return 1;
    if (raw > limit) return limit;
    return raw;
  endfunction

  // The phase stays at zero until the window first fits, then counts modulo the stride.
  // A phase left above a reduced stride falls back to zero on its next advance.
  function automatic int unsigned advance_phase(input int unsigned next_pos,
                                                input int unsigned first,
                                                input int unsigned phase,
                                                input int unsigned stride);
    if (next_pos <= first) return 0;
    return (phase + 1 >= stride) ? 0 : phase + 1;
  endfunction

  // Takes one sample and queues the window maximum that it completes, if any.
  task automatic pool_sample(input sample_t x);
    int unsigned w;
    int unsigned h;
    int unsigned s;
    int unsigned pw;
    int unsigned ph;
    int unsigned r;
    int unsigned c;
    int unsigned nc;
    int unsigned nr;
    sample_t     vmax;
    sample_t     best;
    logic        last_col;
    pooled_t     res;
    w  = clamp_size(win_w_reg, DEF_MAX_WINDOW);
    h  = clamp_size(win_h_reg, DEF_MAX_WINDOW);
    s  = clamp_size(step_reg, DEF_MAX_WINDOW);
    pw = clamp_size(plane_w_reg, DEF_MAX_PLANE_WIDTH);
    ph = clamp_size(plane_h_reg, MAX_PLANE_HEIGHT);
    r  = row_pos;
    c  = col_pos % DEF_MAX_PLANE_WIDTH;

    // Vertical maximum over the rows of the window, then across its columns.
    if (r + 1 >= h) begin
      vmax = x;
      for (int k = 1; k < h; k++) begin
        if (line_rows[(r - k) % LINE_ROWS][c] > vmax) vmax = line_rows[(r - k) % LINE_ROWS][c];
      end
      col_max[c % DEF_MAX_WINDOW] = vmax;
      if (c + 1 >= w && row_phase == 0 && col_phase == 0) begin
        best = vmax;
        for (int k = 1; k < w; k++) begin
          if (col_max[(c - k) % DEF_MAX_WINDOW] > best) best = col_max[(c - k) % DEF_MAX_WINDOW];
        end
        res.value     = best;
        res.row_end   = (c + s >= pw);
        res.plane_end = res.row_end && (r + s >= ph);
        pooled_due.push_back(res);
      end
    end
    line_rows[r % LINE_ROWS][c] = x;

    // Advance the position, wrapping at the end of a row and of a plane.
    last_col  = (c + 1 >= pw);
    nc        = last_col ? 0 : c + 1;
    col_phase = advance_phase(nc, w - 1, col_phase, s);
    col_pos   = nc;
    if (last_col) begin
      nr        = (r + 1 >= ph) ? 0 : r + 1;
      row_phase = advance_phase(nr, h - 1, row_phase, s);
      row_pos   = nr;
    end
  endtask

  always @(posedge clk) begin
    pooled_t want;
    if (rst) begin
      win_w_reg   = RST_WINDOW_WIDTH;
      win_h_reg   = RST_WINDOW_HEIGHT;
      step_reg    = RST_STEP_SIZE;
      plane_w_reg = RST_PLANE_WIDTH;
      plane_h_reg = RST_PLANE_HEIGHT;
      row_pos     = 0;
      col_pos     = 0;
      row_phase   = 0;
      col_phase   = 0;
      fail_count  = 0;
      pooled_due.delete();
    end else begin
      // Register writes.
      if (cfg_write_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_WINDOW_WIDTH:  win_w_reg   = cfg_data[WIN_CFG_W-1:0];
          REG_WINDOW_HEIGHT: win_h_reg   = cfg_data[WIN_CFG_W-1:0];
          REG_STEP_SIZE:     step_reg    = cfg_data[WIN_CFG_W-1:0];
          REG_PLANE_WIDTH:   plane_w_reg = cfg_data[PLANE_CFG_W-1:0];
          REG_PLANE_HEIGHT:  plane_h_reg = cfg_data[PLANE_CFG_W-1:0];
          default: ;
        endcase
      end

      // Accepted sample requests feed the prediction.
      if (feed.valid && feed.ready) pool_sample(feed.sample);

      // Accepted result requests are checked against the oldest prediction.
      if (pooled.valid && pooled.ready) begin
        if (pooled_due.size() == 0) begin
          $error("pooled_value: expected none, got %0d", pooled.pooled_value);
          fail_count++;
        end else begin
          want = pooled_due.pop_front();
          if (pooled.pooled_value !== want.value) begin
            $error("pooled_value: expected %0d, got %0d", want.value, pooled.pooled_value);
            fail_count++;
          end
          if (pooled.row_end !== want.row_end) begin
            $error("row_end: expected %0b, got %0b", want.row_end, pooled.row_end);
            fail_count++;
          end
          if (pooled.plane_end !== want.plane_end) begin
            $error("plane_end: expected %0b, got %0b", want.plane_end, pooled.plane_end);
            fail_count++;
          end
        end
      end
    end
    mismatches  <= fail_count;
    results_due <= pooled_due.size();
  end

endmodule

// ===== bench/tb_max_pooling_2d_stream.sv =====
// Drives planes of samples into the pooling block under a series of register
// settings, with random gaps on both channels, and gives the verdict.
module tb_max_pooling_2d_stream;
  import mpool_pkg::*;

  localparam int SETTLE_CYCLES  = 8;
  localparam int RANDOM_TARGET  = 1650;
  localparam int TIMEOUT_PERIOD = 800000;

  typedef logic [DEF_SAMPLE_BITS-1:0] sample_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int unsigned            mismatches;
  int unsigned            results_due;
  int unsigned            random_samples;
  bit                     feed_calm;

  mpool_sample_if feed ();
  mpool_result_if pooled ();

  max_pooling_2d_stream i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .feed         (feed),
    .pooled       (pooled)
  );

  window_max_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .feed         (feed),
    .pooled       (pooled),
    .mismatches   (mismatches),
    .results_due  (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Plane and window sizes as the block sees them.
  function automatic int unsigned saturate_size(input int unsigned raw, input int unsigned limit);
    if (raw == 0) return 1;
    if (raw > limit) return limit;
    return raw;
  endfunction

  // Window registers carry random junk above their four bits.
  function automatic logic [CFG_DATA_W-1:0] win_data(input int unsigned v);
    logic [CFG_DATA_W-1:0] d;
    d                = CFG_DATA_W'($urandom);
    d[WIN_CFG_W-1:0] = WIN_CFG_W'(v);
    return d;
  endfunction

  // Mostly uniform samples, with the extremes now and then.
  function automatic sample_t pick_sample();
    sample_t corner [4];
    corner = '{16'h8000, 16'h7fff, 16'hffff, 16'h0000};
    if ($urandom_range(0, 7) == 0) return corner[$urandom_range(0, 3)];
    return sample_t'($urandom);
  endfunction

  // One sample request, after a random gap unless the feed runs calm.
  task automatic send_sample(input sample_t s);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) feed_calm = !feed_calm;
    gap = feed_calm ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      feed.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    feed.valid  <= 1'b1;
    feed.sample <= s;
    do @(posedge clk); while (!feed.ready);
  endtask

  // Waits until every predicted result has come, then lets the pipeline settle.
  task automatic wait_idle();
    feed.valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; the caller lowers the write enable after the last one.
  task automatic put_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    @(posedge clk);
  endtask

  // Loads a full setting and sends whole planes of random samples under it.
  task automatic run_phase(input int unsigned w, input int unsigned h, input int unsigned s,
                           input int unsigned pw, input int unsigned ph,
                           input int unsigned planes);
    int unsigned total;
    wait_idle();
    put_reg(REG_WINDOW_WIDTH, win_data(w));
    put_reg(REG_WINDOW_HEIGHT, win_data(h));
    put_reg(REG_STEP_SIZE, win_data(s));
    put_reg(REG_PLANE_WIDTH, CFG_DATA_W'(pw));
    put_reg(REG_PLANE_HEIGHT, CFG_DATA_W'(ph));
    cfg_write_en <= 1'b0;
    total = saturate_size(pw, DEF_MAX_PLANE_WIDTH) * saturate_size(ph, MAX_PLANE_HEIGHT) * planes;
    repeat (total) send_sample(pick_sample());
    random_samples += total;
  endtask

  // Result side: ready drops for a random gap before each result unless the result side runs calm.
  initial begin
    int unsigned hold;
    bit          calm;
    calm = 1'b0;
    pooled.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) calm = !calm;
      hold = calm ? 0 : $urandom_range(0, 5);
      if (hold != 0) begin
        pooled.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      pooled.ready <= 1'b1;
      do @(posedge clk); while (pooled.valid !== 1'b1);
    end
  end

  // Stimulus and verdict.
  initial begin
    sample_t     corner_vals [8];
    int unsigned pw;
    int unsigned ph;
    int unsigned w;
    int unsigned h;
    int unsigned s;
    corner_vals = '{16'h8000, 16'h7fff, 16'hffff, 16'h0000,
                    16'h0001, 16'h0100, 16'h8001, 16'h5555};
    rst            <= 1'b1;
    cfg_write_en   <= 1'b0;
    cfg_index      <= REG_WINDOW_WIDTH;
    cfg_data       <= '0;
    feed.valid     <= 1'b0;
    feed.sample    <= '0;
    random_samples = 0;
    feed_calm      = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset setting: a full first row and the start of the second, so that the
    // default window, stride and width show in the first two results.
    for (int i = 0; i < 32; i++) send_sample(corner_vals[(i * 3) % 8]);

    // The column phase is now one; a stride of one leaves it equal to the stride.
    wait_idle();
    put_reg(REG_STEP_SIZE, win_data(1));
    cfg_write_en <= 1'b0;
    send_sample(16'h7ffe);

    // Width and height shrink below the current position, which ends the row
    // and the plane at the next sample.
    wait_idle();
    put_reg(REG_PLANE_WIDTH, CFG_DATA_W'(3));
    put_reg(REG_PLANE_HEIGHT, CFG_DATA_W'(1));
    cfg_write_en <= 1'b0;
    send_sample(16'h8000);

    // Extreme settings: all zero, window beyond the plane, a single exact
    // window, heavy overlap, the widest plane and a tall single-column plane.
    run_phase(0, 0, 0, 0, 0, 3);
    run_phase(15, 15, 15, 5, 4, 2);
    run_phase(8, 8, 8, 8, 8, 1);
    run_phase(8, 8, 1, 10, 9, 1);
    run_phase(1, 1, 8, 2047, 1, 1);
    run_phase(1, 8, 8, 1, 200, 1);

    // Random settings, mostly with a window that fits the plane.
    while (random_samples < RANDOM_TARGET) begin
      if ($urandom_range(0, 9) == 0) begin
        pw = $urandom_range(0, 24);
        ph = $urandom_range(0, 24);
      end else begin
        pw = $urandom_range(1, 12);
        ph = $urandom_range(1, 12);
      end
      if ($urandom_range(0, 7) == 0) begin
        w = $urandom_range(0, 15);
        h = $urandom_range(0, 15);
      end else begin
        w = $urandom_range(1, saturate_size(pw, DEF_MAX_WINDOW));
        h = $urandom_range(1, saturate_size(ph, DEF_MAX_WINDOW));
      end
      s = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
      run_phase(w, h, s, pw, ph, $urandom_range(1, 3));
    end

    wait_idle();
    if (mismatches == 0 && results_due == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #TIMEOUT_PERIOD;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
